[sv/mesp_pkg.sv]
// ----------------------------------------------------------------------------
// mesp_pkg
// Shared types and codes of the music event stream parser.
// ----------------------------------------------------------------------------
package mesp_pkg;

	localparam int DELAY_FIELD_W = 28;
	localparam logic [31:0] DELAY_FIELD_MAX = 32'h0FFF_FFFF;

	localparam logic [2:0] KIND_RELEASE    = 3'd0;
	localparam logic [2:0] KIND_PLAY       = 3'd1;
	localparam logic [2:0] KIND_BEND       = 3'd2;
	localparam logic [2:0] KIND_SYSTEM     = 3'd3;
	localparam logic [2:0] KIND_CONTROLLER = 3'd4;
	localparam logic [2:0] KIND_SCORE_END  = 3'd5;
	localparam logic [2:0] KIND_DELAY      = 3'd6;
	localparam logic [2:0] KIND_STOP       = 3'd7;

	localparam logic [2:0] TYPE_RELEASE    = 3'd0;
	localparam logic [2:0] TYPE_PLAY       = 3'd1;
	localparam logic [2:0] TYPE_BEND       = 3'd2;
	localparam logic [2:0] TYPE_SYSTEM     = 3'd3;
	localparam logic [2:0] TYPE_CONTROLLER = 3'd4;
	localparam logic [2:0] TYPE_BAD_A      = 3'd5;
	localparam logic [2:0] TYPE_SCORE_END  = 3'd6;
	localparam logic [2:0] TYPE_BAD_B      = 3'd7;

	typedef struct packed {
		logic [2:0]               event_kind;
		logic [3:0]               channel;
		logic [6:0]               note;
		logic                     volume_present;
		logic [6:0]               volume;
		logic [6:0]               controller_number;
		logic [7:0]               event_value;
		logic [DELAY_FIELD_W-1:0] delay_ticks;
		logic                     stream_stopped;
	} res_t;

endpackage

[sv/mesp_if.sv]
// ----------------------------------------------------------------------------
// mesp_if
// Valid/ready channels of the parser: the byte stream and the event results.
// ----------------------------------------------------------------------------
interface mesp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface mesp_event_if;
	logic                                valid;
	logic                                ready;
	logic [2:0]                          event_kind;
	logic [3:0]                          channel;
	logic [6:0]                          note;
	logic                                volume_present;
	logic [6:0]                          volume;
	logic [6:0]                          controller_number;
	logic [7:0]                          event_value;
	logic [mesp_pkg::DELAY_FIELD_W-1:0]  delay_ticks;
	logic                                stream_stopped;

	modport source (output valid, output event_kind, output channel, output note,
		output volume_present, output volume, output controller_number,
		output event_value, output delay_ticks, output stream_stopped, input ready);
	modport sink (input valid, input event_kind, input channel, input note,
		input volume_present, input volume, input controller_number,
		input event_value, input delay_ticks, input stream_stopped, output ready);
endinterface

[sv/mesp_parser.sv]
// ----------------------------------------------------------------------------
// mesp_parser
// Parse state machine: decodes one byte per step and builds the result.
// ----------------------------------------------------------------------------
module mesp_parser #(
	parameter int DELAY_BITS = 28
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      data_byte,
	input  logic            loop_enable,
	output logic            has_result,
	output mesp_pkg::res_t  result
);

	localparam logic [2:0] PH_STATUS  = 3'd0;
	localparam logic [2:0] PH_PAYLOAD = 3'd1;
	localparam logic [2:0] PH_VOLUME  = 3'd2;
	localparam logic [2:0] PH_CTRLVAL = 3'd3;
	localparam logic [2:0] PH_DELAY   = 3'd4;

	logic [2:0]            phase_q, phase_d;
	logic [2:0]            type_q, type_d;
	logic [3:0]            chan_q, chan_d;
	logic                  last_q, last_d;
	logic [6:0]            first_q, first_d;
	logic [DELAY_BITS-1:0] accum_q, accum_d;
	logic                  stopped_q, stopped_d;

	logic [DELAY_BITS+6:0] accum_wide;
	logic [DELAY_BITS-1:0] accum_grown;
	logic [31:0]           accum_ext;
	logic [2:0]            status_type;

	assign status_type = data_byte[6:4];
	assign accum_wide  = {accum_q, data_byte[6:0]};
	assign accum_grown = (accum_q[DELAY_BITS-1:DELAY_BITS-7] != 7'd0) ?
		{DELAY_BITS{1'b1}} : accum_wide[DELAY_BITS-1:0];
	assign accum_ext   = 32'(accum_grown);

	always_comb begin
		phase_d    = phase_q;
		type_d     = type_q;
		chan_d     = chan_q;
		last_d     = last_q;
		first_d    = first_q;
		accum_d    = accum_q;
		stopped_d  = stopped_q;
		has_result = 1'b0;
		result     = '0;
		if (!stopped_q) begin
			case (phase_q)
				PH_STATUS: begin
					result.channel = data_byte[3:0];
					if (status_type == mesp_pkg::TYPE_SCORE_END) begin
						has_result            = 1'b1;
						result.event_kind     = mesp_pkg::KIND_SCORE_END;
						result.stream_stopped = !loop_enable;
						stopped_d             = !loop_enable;
					end else if (status_type == mesp_pkg::TYPE_BAD_A ||
							status_type == mesp_pkg::TYPE_BAD_B) begin
						has_result            = 1'b1;
						result.event_kind     = mesp_pkg::KIND_STOP;
						result.stream_stopped = 1'b1;
						stopped_d             = 1'b1;
					end else begin
						type_d  = status_type;
						chan_d  = data_byte[3:0];
						last_d  = data_byte[7];
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					result.channel = chan_q;
					case (type_q)
						mesp_pkg::TYPE_RELEASE: begin
							has_result        = 1'b1;
							result.event_kind = mesp_pkg::KIND_RELEASE;
							result.note       = data_byte[6:0];
						end
						mesp_pkg::TYPE_PLAY: begin
							if (data_byte[7]) begin
								first_d = data_byte[6:0];
							end else begin
								has_result        = 1'b1;
								result.event_kind = mesp_pkg::KIND_PLAY;
								result.note       = data_byte[6:0];
							end
						end
						mesp_pkg::TYPE_BEND: begin
							has_result         = 1'b1;
							result.event_kind  = mesp_pkg::KIND_BEND;
							result.event_value = data_byte;
						end
						mesp_pkg::TYPE_SYSTEM: begin
							has_result               = 1'b1;
							result.event_kind        = mesp_pkg::KIND_SYSTEM;
							result.controller_number = data_byte[6:0];
						end
						default: begin
							first_d = data_byte[6:0];
						end
					endcase
					if (!has_result) begin
						phase_d = (type_q == mesp_pkg::TYPE_PLAY) ? PH_VOLUME : PH_CTRLVAL;
					end
				end
				PH_VOLUME: begin
					has_result            = 1'b1;
					result.event_kind     = mesp_pkg::KIND_PLAY;
					result.channel        = chan_q;
					result.note           = first_q;
					result.volume_present = 1'b1;
					result.volume         = data_byte[6:0];
				end
				PH_CTRLVAL: begin
					has_result               = 1'b1;
					result.event_kind        = mesp_pkg::KIND_CONTROLLER;
					result.channel           = chan_q;
					result.controller_number = first_q;
					result.event_value       = {1'b0, data_byte[6:0]};
				end
				PH_DELAY: begin
					accum_d = accum_grown;
					if (!data_byte[7]) begin
						has_result         = 1'b1;
						result.event_kind  = mesp_pkg::KIND_DELAY;
						result.delay_ticks = (accum_ext > mesp_pkg::DELAY_FIELD_MAX) ?
							{mesp_pkg::DELAY_FIELD_W{1'b1}} :
							accum_ext[mesp_pkg::DELAY_FIELD_W-1:0];
						phase_d            = PH_STATUS;
					end
				end
				default: begin
					phase_d = PH_STATUS;
				end
			endcase
			if (has_result && phase_q != PH_STATUS && phase_q != PH_DELAY) begin
				if (last_q) begin
					accum_d = '0;
					phase_d = PH_DELAY;
				end else begin
					phase_d = PH_STATUS;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STATUS;
			type_q    <= '0;
			chan_q    <= '0;
			last_q    <= 1'b0;
			first_q   <= '0;
			accum_q   <= '0;
			stopped_q <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			type_q    <= type_d;
			chan_q    <= chan_d;
			last_q    <= last_d;
			first_q   <= first_d;
			accum_q   <= accum_d;
			stopped_q <= stopped_d;
		end
	end

endmodule

[sv/mus_event_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// mus_event_stream_parser_core
// Parses a packed music event byte stream into decoded event transactions.
// ----------------------------------------------------------------------------
// The byte channel takes one data byte per transaction and the event channel
// gives at most one decoded event per byte. A release, bend or system event
// takes two bytes, a controller or a play with volume takes three, and a
// delay takes one byte per 7-bit group.
// Each accepted byte sits in an input register, is decoded by the parse
// state machine and lands in the result register, which drives the event
// channel. Throughput is one byte per cycle while the receiver does not
// stall; the parse state machine is the only loop.
// When the receiver stalls, the result register holds its event and the
// input register still takes one more byte, after which the byte channel
// stalls too. The user must write the loop enable register (cfg_we/cfg_wdata)
// only while the block is idle; the block itself does not enforce this.
// Reset clears the parse state, the stop flag and the loop enable; the block
// takes bytes right after reset. Once stopped, bytes are taken and dropped
// until the next reset.
// ----------------------------------------------------------------------------
module mus_event_stream_parser_core #(
	parameter int DELAY_BITS = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	mesp_byte_if.sink     bytes,
	mesp_event_if.source  events
);

	logic            loop_en_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            advance;
	logic            step;
	logic            has_result;
	mesp_pkg::res_t  result;
	logic            out_valid_q;
	mesp_pkg::res_t  out_q;

	assign advance     = valid_s1 && (!out_valid_q || events.ready);
	assign step        = advance;
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_en_q <= 1'b0;
		end else if (cfg_we) begin
			loop_en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
		end
	end

	mesp_parser #(
		.DELAY_BITS(DELAY_BITS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (byte_s1),
		.loop_enable(loop_en_q),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && has_result) begin
			out_valid_q <= 1'b1;
		end else if (events.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_result) begin
			out_q <= result;
		end
	end

	assign events.valid             = out_valid_q;
	assign events.event_kind        = out_q.event_kind;
	assign events.channel           = out_q.channel;
	assign events.note              = out_q.note;
	assign events.volume_present    = out_q.volume_present;
	assign events.volume            = out_q.volume;
	assign events.controller_number = out_q.controller_number;
	assign events.event_value       = out_q.event_value;
	assign events.delay_ticks       = out_q.delay_ticks;
	assign events.stream_stopped    = out_q.stream_stopped;

`ifndef ASSERT_OFF
	a_stop_kind: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.stream_stopped |->
			events.event_kind == mesp_pkg::KIND_SCORE_END ||
			events.event_kind == mesp_pkg::KIND_STOP)
		else $error("Stopped flag on an event that cannot stop the stream.");

	a_delay_chan: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.event_kind == mesp_pkg::KIND_DELAY |->
			events.channel == 4'd0 && events.note == 7'd0)
		else $error("Delay event carries event fields.");

	a_silent_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.ready && events.stream_stopped |=> !events.valid)
		else $error("Event given after the stream stopped.");

	a_step_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !out_valid_q || events.ready)
		else $error("Result register overwritten while stalled.");
`endif

endmodule
